@@ src/rav_pkg.sv @@
`default_nettype none
package rav_pkg;
    localparam int DATA_W    = 32;
    localparam int INERTIA_W = 31;
    localparam int TS_W      = 17;
    localparam int DG_W      = 22;
    localparam int CFG_W     = 22;
    localparam int DIV_W     = 48;
    localparam int KSUM_W    = 36;

    localparam logic [TS_W-1:0] TS_RESET = 17'd655;
    localparam logic [DG_W-1:0] DG_RESET = 22'd655360;

    localparam logic [0:0] CFG_TIME_STEP = 1'b0;
    localparam logic [0:0] CFG_DAMPING   = 1'b1;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [1:0] STAGE_LAST = 2'd3;

    typedef logic [3:0] op_t;
    localparam op_t OP_NOP   = 4'd0;
    localparam op_t OP_LOAD  = 4'd1;
    localparam op_t OP_HDIV  = 4'd2;
    localparam op_t OP_HSAVE = 4'd3;
    localparam op_t OP_ARGS  = 4'd4;
    localparam op_t OP_MUL1  = 4'd5;
    localparam op_t OP_MUL2  = 4'd6;
    localparam op_t OP_NUM   = 4'd7;
    localparam op_t OP_QDIV  = 4'd8;
    localparam op_t OP_MUL3  = 4'd9;
    localparam op_t OP_ACC   = 4'd10;
    localparam op_t OP_MUL4  = 4'd11;
    localparam op_t OP_KSAVE = 4'd12;
    localparam op_t OP_WDIV  = 4'd13;
    localparam op_t OP_WUPD  = 4'd14;
    localparam op_t OP_OUT   = 4'd15;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic [1:0] stage;
    } rav_cmd_t;

    typedef struct packed {
        logic div_done;
    } rav_stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     hit;
    } sat_t;

    localparam logic signed [65:0] VMAX66 = 66'sd2147483647;
    localparam logic signed [65:0] VMIN66 = -66'sd2147483648;
    localparam logic signed [DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VMIN = 32'sh8000_0000;

    function automatic sat_t sat32(input logic signed [65:0] v);
        sat_t r;
        if (v > VMAX66) begin
            r.value = VMAX;
            r.hit   = 1'b1;
        end else if (v < VMIN66) begin
            r.value = VMIN;
            r.hit   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.hit   = 1'b0;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

@@ src/rav_div.sv @@
`default_nettype none
module rav_div (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic signed [rav_pkg::DIV_W-1:0]   dividend,
    input  wire logic [rav_pkg::INERTIA_W-1:0]      divisor,
    output logic                                    done,
    output logic signed [rav_pkg::DIV_W:0]          quotient
);
    import rav_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [31:0]          rem_reg;
    logic [INERTIA_W-1:0] dvs_reg;
    logic                 neg_reg;

    logic [31:0]    rem_sh;
    logic [32:0]    trial;
    logic           ge;
    logic [DIV_W-1:0] mag;

    assign rem_sh = {rem_reg[30:0], q_reg[DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~trial[32];
    assign mag    = dividend[DIV_W-1] ? (DIV_W'(0) - dividend) : dividend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DIV_W-1];
        end else if (busy_reg) begin
            rem_reg <= ge ? trial[31:0] : rem_sh;
            q_reg   <= {q_reg[DIV_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
endmodule
`default_nettype wire

@@ src/rav_datapath.sv @@
`default_nettype none
module rav_datapath #(
    parameter int INNER_STEPS = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire rav_pkg::rav_cmd_t                  cmd,
    output rav_pkg::rav_stat_t                      stat,
    input  wire logic                               cfg_wr_en,
    input  wire logic [0:0]                         cfg_index,
    input  wire logic [rav_pkg::CFG_W-1:0]          cfg_wr_data,
    input  wire logic [rav_pkg::INERTIA_W-1:0]      inertia_x,
    input  wire logic [rav_pkg::INERTIA_W-1:0]      inertia_y,
    input  wire logic [rav_pkg::INERTIA_W-1:0]      inertia_z,
    input  wire logic signed [rav_pkg::DATA_W-1:0]  torque_x,
    input  wire logic signed [rav_pkg::DATA_W-1:0]  torque_y,
    input  wire logic signed [rav_pkg::DATA_W-1:0]  torque_z,
    output logic signed [rav_pkg::DATA_W-1:0]       omega_out_x,
    output logic signed [rav_pkg::DATA_W-1:0]       omega_out_y,
    output logic signed [rav_pkg::DATA_W-1:0]       omega_out_z,
    output logic                                    fault
);
    import rav_pkg::*;

    // h = ts / INNER_STEPS by reciprocal, exact for any 17-bit ts
    localparam int H_RECIP_I = ((1 << 24) + INNER_STEPS - 1) / INNER_STEPS;
    localparam logic [24:0] H_RECIP = 25'(H_RECIP_I);
    // divide by 6 one 12-bit digit per cycle, digit quotient by reciprocal
    localparam logic [15:0] RECIP6  = 16'd43691;
    localparam logic [1:0]  D6_LAST = 2'd2;

    logic [TS_W-1:0]            ts_reg;
    logic [DG_W-1:0]            dg_reg;
    logic [INERTIA_W-1:0]       iner_reg [3];
    logic signed [DATA_W-1:0]   torq_reg [3];
    logic signed [DATA_W-1:0]   w_reg    [3];
    logic signed [DATA_W-1:0]   a_reg    [3];
    logic signed [DATA_W-1:0]   kprev_reg[3];
    logic signed [KSUM_W-1:0]   ksum_reg [3];
    logic [TS_W-1:0]            h_reg;
    logic [41:0]                hprod_reg;
    logic signed [63:0]         mul_reg;
    logic signed [DATA_W-1:0]   num_reg;
    logic signed [DATA_W-1:0]   quot_reg;
    logic signed [DATA_W-1:0]   acc_reg;
    logic                       fault_reg;
    logic signed [DATA_W-1:0]   ox_reg, oy_reg, oz_reg;
    logic                       ofault_reg;
    logic                       d6_busy_reg;
    logic                       d6_done_reg;
    logic [1:0]                 d6_cnt_reg;
    logic [KSUM_W-1:0]          d6_mag_reg;
    logic [KSUM_W-1:0]          d6_q_reg;
    logic [2:0]                 d6_rem_reg;
    logic                       d6_neg_reg;

    logic signed [DATA_W-1:0]   wa, wb, wc, na, wself;
    logic [INERTIA_W-1:0]       ia, ib, ic;
    logic signed [KSUM_W-1:0]   ks;

    always_comb begin
        unique case (cmd.axis)
            AX_Y: begin
                wa = a_reg[1]; wb = a_reg[2]; wc = a_reg[0];
                ia = iner_reg[1]; ib = iner_reg[2]; ic = iner_reg[0];
                na = torq_reg[1]; wself = w_reg[1]; ks = ksum_reg[1];
            end
            AX_Z: begin
                wa = a_reg[2]; wb = a_reg[0]; wc = a_reg[1];
                ia = iner_reg[2]; ib = iner_reg[0]; ic = iner_reg[1];
                na = torq_reg[2]; wself = w_reg[2]; ks = ksum_reg[2];
            end
            default: begin
                wa = a_reg[0]; wb = a_reg[1]; wc = a_reg[2];
                ia = iner_reg[0]; ib = iner_reg[1]; ic = iner_reg[2];
                na = torq_reg[0]; wself = w_reg[0]; ks = ksum_reg[0];
            end
        endcase
    end

    logic signed [DATA_W-1:0]   diff_bc;
    logic signed [63:0]         mul_sh;
    sat_t                       sat_m;
    logic signed [DATA_W-1:0]   mul_a, mul_b;
    logic signed [32:0]         num_sum;
    sat_t                       sat_num;
    logic                       div_start;
    logic signed [DIV_W-1:0]    div_dvd;
    logic [INERTIA_W-1:0]       div_dvs;
    logic                       div_done;
    logic signed [DIV_W:0]      div_q;
    sat_t                       sat_q;
    logic signed [DATA_W-1:0]   quot_val;
    logic                       quot_hit;
    logic signed [32:0]         acc_sum;
    sat_t                       sat_acc;
    logic signed [32:0]         w_sum;
    sat_t                       sat_w;
    logic signed [DATA_W-1:0]   k_add  [3];
    logic signed [32:0]         arg_sum[3];
    sat_t                       sat_arg[3];
    logic signed [KSUM_W-1:0]   k_wt;
    logic [KSUM_W-1:0]          ks_mag;
    logic [14:0]                d6_v;
    logic [30:0]                d6_prod;
    logic [11:0]                d6_qd;
    logic [14:0]                d6_left;
    logic signed [KSUM_W-1:0]   d6_quot;

    assign diff_bc = $signed({1'b0, ib}) - $signed({1'b0, ic});
    assign mul_sh  = mul_reg >>> 16;
    assign sat_m   = sat32({{2{mul_sh[63]}}, mul_sh});

    always_comb begin
        case (cmd.op)
            OP_MUL1: begin mul_a = diff_bc; mul_b = wb; end
            OP_MUL2: begin mul_a = sat_m.value; mul_b = wc; end
            OP_MUL3: begin mul_a = $signed({10'd0, dg_reg}); mul_b = wa; end
            default: begin mul_a = $signed({15'd0, h_reg}); mul_b = acc_reg; end
        endcase
    end

    assign num_sum = $signed({na[31], na}) + $signed({sat_m.value[31], sat_m.value});
    assign sat_num = sat32({{33{num_sum[32]}}, num_sum});

    assign div_start = (cmd.op == OP_QDIV);
    assign div_dvd   = {num_reg, 16'd0};
    assign div_dvs   = ia;

    rav_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sat_q = sat32({{(65-DIV_W){div_q[DIV_W]}}, div_q});

    always_comb begin
        if (ia == '0) begin
            quot_hit = 1'b1;
            if (num_reg > 0)      quot_val = VMAX;
            else if (num_reg < 0) quot_val = VMIN;
            else                  quot_val = '0;
        end else begin
            quot_hit = sat_q.hit;
            quot_val = sat_q.value;
        end
    end

    assign acc_sum = $signed({quot_reg[31], quot_reg})
                   - $signed({sat_m.value[31], sat_m.value});
    assign sat_acc = sat32({{33{acc_sum[32]}}, acc_sum});

    assign ks_mag  = ks[KSUM_W-1] ? $unsigned(-ks) : $unsigned(ks);
    assign d6_v    = {d6_rem_reg, d6_mag_reg[KSUM_W-1 -: 12]};
    assign d6_prod = {16'd0, d6_v} * {15'd0, RECIP6};
    assign d6_qd   = d6_prod[29:18];
    assign d6_left = d6_v - ({3'd0, d6_qd} << 2) - ({3'd0, d6_qd} << 1);
    assign d6_quot = d6_neg_reg ? -$signed(d6_q_reg) : $signed(d6_q_reg);

    assign w_sum = $signed({wself[31], wself}) + $signed(d6_quot[32:0]);
    assign sat_w = sat32({{33{w_sum[32]}}, w_sum});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            k_add[i]   = (cmd.stage == STAGE_LAST) ? kprev_reg[i] : (kprev_reg[i] >>> 1);
            arg_sum[i] = $signed({w_reg[i][31], w_reg[i]}) + $signed({k_add[i][31], k_add[i]});
            sat_arg[i] = sat32({{33{arg_sum[i][32]}}, arg_sum[i]});
        end
    end

    // middle stages count twice in the RK4 sum
    assign k_wt = (cmd.stage == 2'd1 || cmd.stage == 2'd2)
                ? ({{(KSUM_W-DATA_W){sat_m.value[31]}}, sat_m.value} <<< 1)
                :  {{(KSUM_W-DATA_W){sat_m.value[31]}}, sat_m.value};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d6_busy_reg <= 1'b0;
            d6_done_reg <= 1'b0;
            d6_cnt_reg  <= '0;
        end else begin
            d6_done_reg <= 1'b0;
            if (cmd.op == OP_WDIV) begin
                d6_busy_reg <= 1'b1;
                d6_cnt_reg  <= '0;
            end else if (d6_busy_reg) begin
                d6_cnt_reg <= d6_cnt_reg + 2'd1;
                if (d6_cnt_reg == D6_LAST) begin
                    d6_busy_reg <= 1'b0;
                    d6_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WDIV) begin
            d6_mag_reg <= ks_mag;
            d6_q_reg   <= '0;
            d6_rem_reg <= '0;
            d6_neg_reg <= ks[KSUM_W-1];
        end else if (d6_busy_reg) begin
            d6_mag_reg <= {d6_mag_reg[KSUM_W-13:0], 12'd0};
            d6_q_reg   <= {d6_q_reg[KSUM_W-13:0], d6_qd};
            d6_rem_reg <= d6_left[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ts_reg    <= TS_RESET;
            dg_reg    <= DG_RESET;
            fault_reg <= 1'b0;
            for (int i = 0; i < 3; i++) w_reg[i] <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_TIME_STEP: ts_reg <= cfg_wr_data[TS_W-1:0];
                    CFG_DAMPING:   dg_reg <= cfg_wr_data[DG_W-1:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOAD: fault_reg <= (inertia_x == '0) || (inertia_y == '0)
                                   || (inertia_z == '0);
                OP_ARGS: if (cmd.stage != 2'd0) begin
                    fault_reg <= fault_reg | sat_arg[0].hit | sat_arg[1].hit
                               | sat_arg[2].hit;
                end
                OP_MUL2: fault_reg <= fault_reg | sat_m.hit;
                OP_NUM:  fault_reg <= fault_reg | sat_m.hit | sat_num.hit;
                OP_MUL3: fault_reg <= fault_reg | quot_hit;
                OP_ACC:  fault_reg <= fault_reg | sat_m.hit | sat_acc.hit;
                OP_KSAVE: fault_reg <= fault_reg | sat_m.hit;
                OP_WUPD: begin
                    fault_reg <= fault_reg | sat_w.hit;
                    for (int i = 0; i < 3; i++) begin
                        if (cmd.axis == 2'(i)) w_reg[i] <= sat_w.value;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                iner_reg[0] <= inertia_x;
                iner_reg[1] <= inertia_y;
                iner_reg[2] <= inertia_z;
                torq_reg[0] <= torque_x;
                torq_reg[1] <= torque_y;
                torq_reg[2] <= torque_z;
                for (int i = 0; i < 3; i++) ksum_reg[i] <= '0;
            end
            OP_HDIV:  hprod_reg <= 42'(ts_reg) * 42'(H_RECIP);
            OP_HSAVE: h_reg <= hprod_reg[24 +: TS_W];
            OP_ARGS: begin
                for (int i = 0; i < 3; i++) begin
                    a_reg[i] <= (cmd.stage == 2'd0) ? w_reg[i] : sat_arg[i].value;
                end
            end
            OP_MUL1, OP_MUL2, OP_MUL4: mul_reg <= mul_a * mul_b;
            OP_NUM:  num_reg <= sat_num.value;
            OP_MUL3: begin
                mul_reg  <= mul_a * mul_b;
                quot_reg <= quot_val;
            end
            OP_ACC:  acc_reg <= sat_acc.value;
            OP_KSAVE: begin
                for (int i = 0; i < 3; i++) begin
                    if (cmd.axis == 2'(i)) begin
                        kprev_reg[i] <= sat_m.value;
                        ksum_reg[i]  <= ksum_reg[i] + k_wt;
                    end
                end
            end
            OP_WUPD: begin
                for (int i = 0; i < 3; i++) begin
                    if (cmd.axis == 2'(i)) ksum_reg[i] <= '0;
                end
            end
            OP_OUT: begin
                ox_reg     <= w_reg[0];
                oy_reg     <= w_reg[1];
                oz_reg     <= w_reg[2];
                ofault_reg <= fault_reg;
            end
            default: ;
        endcase
    end

    assign stat.div_done = div_done | d6_done_reg;
    assign omega_out_x   = ox_reg;
    assign omega_out_y   = oy_reg;
    assign omega_out_z   = oz_reg;
    assign fault         = ofault_reg;
endmodule
`default_nettype wire

@@ src/rav_ctrl.sv @@
`default_nettype none
module rav_ctrl #(
    parameter int INNER_STEPS = 10
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output rav_pkg::rav_cmd_t        cmd,
    input  wire rav_pkg::rav_stat_t  stat
);
    import rav_pkg::*;

    localparam int SW = (INNER_STEPS > 1) ? $clog2(INNER_STEPS) : 1;
    localparam logic [SW-1:0] STEP_LAST = SW'(INNER_STEPS - 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HDIV   = 5'd1;
    localparam logic [4:0] S_HSAVE  = 5'd3;
    localparam logic [4:0] S_ARGS   = 5'd4;
    localparam logic [4:0] S_MUL1   = 5'd5;
    localparam logic [4:0] S_MUL2   = 5'd6;
    localparam logic [4:0] S_NUM    = 5'd7;
    localparam logic [4:0] S_QDIV   = 5'd8;
    localparam logic [4:0] S_QWAIT  = 5'd9;
    localparam logic [4:0] S_MUL3   = 5'd10;
    localparam logic [4:0] S_ACC    = 5'd11;
    localparam logic [4:0] S_MUL4   = 5'd12;
    localparam logic [4:0] S_KSAVE  = 5'd13;
    localparam logic [4:0] S_WDIV   = 5'd14;
    localparam logic [4:0] S_WWAIT  = 5'd15;
    localparam logic [4:0] S_WUPD   = 5'd16;
    localparam logic [4:0] S_FINISH = 5'd17;

    logic [4:0]    state_reg, state_next;
    logic [1:0]    axis_reg, axis_next;
    logic [1:0]    stage_reg, stage_next;
    logic [SW-1:0] step_reg, step_next;
    logic          ovalid_reg, ovalid_next;
    op_t           op;
    logic          out_free;

    assign out_free = !ovalid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        stage_next  = stage_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg && !m_tready;
        op          = OP_NOP;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                op = OP_LOAD;
                state_next = S_HDIV;
            end
            S_HDIV: begin
                op = OP_HDIV;
                state_next = S_HSAVE;
            end
            S_HSAVE: begin
                op = OP_HSAVE;
                step_next  = '0;
                stage_next = '0;
                axis_next  = AX_X;
                state_next = S_ARGS;
            end
            S_ARGS: begin
                op = OP_ARGS;
                axis_next  = AX_X;
                state_next = S_MUL1;
            end
            S_MUL1: begin op = OP_MUL1; state_next = S_MUL2; end
            S_MUL2: begin op = OP_MUL2; state_next = S_NUM; end
            S_NUM:  begin op = OP_NUM;  state_next = S_QDIV; end
            S_QDIV: begin op = OP_QDIV; state_next = S_QWAIT; end
            S_QWAIT: if (stat.div_done) state_next = S_MUL3;
            S_MUL3: begin op = OP_MUL3; state_next = S_ACC; end
            S_ACC:  begin op = OP_ACC;  state_next = S_MUL4; end
            S_MUL4: begin op = OP_MUL4; state_next = S_KSAVE; end
            S_KSAVE: begin
                op = OP_KSAVE;
                if (axis_reg == AX_Z) begin
                    axis_next = AX_X;
                    if (stage_reg == STAGE_LAST) begin
                        state_next = S_WDIV;
                    end else begin
                        stage_next = stage_reg + 2'd1;
                        state_next = S_ARGS;
                    end
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_MUL1;
                end
            end
            S_WDIV: begin op = OP_WDIV; state_next = S_WWAIT; end
            S_WWAIT: if (stat.div_done) state_next = S_WUPD;
            S_WUPD: begin
                op = OP_WUPD;
                if (axis_reg == AX_Z) begin
                    axis_next  = AX_X;
                    stage_next = '0;
                    if (step_reg == STEP_LAST) begin
                        state_next = S_FINISH;
                    end else begin
                        step_next  = step_reg + SW'(1);
                        state_next = S_ARGS;
                    end
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_WDIV;
                end
            end
            S_FINISH: if (out_free) begin
                op = OP_OUT;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            axis_reg   <= AX_X;
            stage_reg  <= '0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            stage_reg  <= stage_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign cmd.op    = op;
    assign cmd.axis  = axis_reg;
    assign cmd.stage = stage_reg;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = ovalid_reg;

    a_finish_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FINISH && out_free) |=> ovalid_reg)
        else $error("finished result not presented");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_HDIV))
        else $error("accepted request did not start work");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (state_reg == S_QWAIT || state_reg == S_WWAIT))
        else $error("divider finished outside a wait state");
endmodule
`default_nettype wire

@@ src/rigid_angular_velocity_rk4.sv @@
// m_tvalid rises once the result of an accepted request is registered. The next request is
// taken once the result is registered; a result still waiting on m_tready does not stall the
// next request, only the presenting of the next result. Run time is set chiefly by the
// shared bit-serial divider, used for every division by inertia on every axis and substep.
// Reset (aresetn low, synchronous): velocity cleared, time_step 655, damping_gain 10.0.
`default_nettype none
module rigid_angular_velocity_rk4 #(
    parameter int INNER_STEPS = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // inertia_x[30:0], inertia_y[61:31], inertia_z[92:62],
    // torque_x[124:93], torque_y[156:125], torque_z[188:157], zero pad
    input  wire logic [191:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // omega_out_x[31:0], omega_out_y[63:32], omega_out_z[95:64]
    output logic [95:0]        m_tdata,
    // fault[0]
    output logic [0:0]         m_tuser,
    input  wire logic          cfg_wr_en,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [21:0]   cfg_wr_data
);
    import rav_pkg::*;

    rav_cmd_t  cmd;
    rav_stat_t stat;
    logic signed [DATA_W-1:0] ox, oy, oz;
    logic fault;

    rav_ctrl #(.INNER_STEPS(INNER_STEPS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rav_datapath #(.INNER_STEPS(INNER_STEPS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .inertia_x   (s_tdata[30:0]),
        .inertia_y   (s_tdata[61:31]),
        .inertia_z   (s_tdata[92:62]),
        .torque_x    ($signed(s_tdata[124:93])),
        .torque_y    ($signed(s_tdata[156:125])),
        .torque_z    ($signed(s_tdata[188:157])),
        .omega_out_x (ox),
        .omega_out_y (oy),
        .omega_out_z (oz),
        .fault       (fault)
    );

    assign m_tdata = {oz, oy, ox};
    assign m_tuser = fault;
endmodule
`default_nettype wire
